// File: src/itmb_pkg.sv
// Shared types and constants for the tile mosaic builder.
// No dependencies; imported by every module of the block but the frame store.
package itmb_pkg;

	// Input item kinds, carried in s_tuser
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Field widths
	localparam int DIM_BITS   = 9;
	localparam int POS_BITS   = 8;
	localparam int VALUE_BITS = 16;

	localparam logic [DIM_BITS-1:0] FRAME_DIM_RESET = 9'd128;
	localparam logic [DIM_BITS-1:0] TILE_DIM_MAX    = 9'd256;

	// Per-item control decided at placement time
	typedef struct packed {
		logic mode;      // item kind
		logic wr_en;     // item writes the store back
		logic clip;      // tile pixel dropped outside the frame
		logic done;      // tile pixel completed the frame
	} itmb_ctl_t;

endpackage

// File: src/itmb_store.sv
// Frame store: single-port-write, registered-read memory with write bypass
// and a zeroing sweep after reset. Depends on nothing but its parameters.
module itmb_store #(
	parameter int AW = 16,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          clear_busy,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] raddr_q;
	logic [AW:0]   clr_cnt_q;
	logic          lw_valid_q;
	logic [AW-1:0] lw_addr_q;
	logic [DW-1:0] lw_data_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;

	assign clear_busy = !clr_cnt_q[AW];

	// sweep owns the write port until every entry is zero
	always_comb begin
		if (clear_busy) begin
			we    = 1'b1;
			waddr = clr_cnt_q[AW-1:0];
			wdata = '0;
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			lw_valid_q <= 1'b0;
		end else begin
			if (clear_busy)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (we)
				lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
			lw_addr_q  <= waddr;
			lw_data_q  <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	// read-first memory: a write on the read edge is picked up from the bypass
	assign rd_data = (lw_valid_q && lw_addr_q == raddr_q) ? lw_data_q : rdata_q;

endmodule

// File: src/itmb_place.sv
// Tile placement: frame size registers, tile position and frame offsets,
// store address and per-item control. Depends on itmb_pkg.
module itmb_place import itmb_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int CW         = 8,
	parameter int RW         = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]     cfg_data,
	input  logic                    accept,
	input  logic                    mode,
	input  logic [DIM_BITS-1:0]     tile_width,
	input  logic [DIM_BITS-1:0]     tile_height,
	input  logic [POS_BITS-1:0]     read_col,
	input  logic [POS_BITS-1:0]     read_row,
	output logic [RW+CW-1:0]        addr,
	output itmb_ctl_t               ctl
);

	logic [DIM_BITS-1:0] frame_width_q, frame_height_q;
	logic [DIM_BITS-1:0] col_offset_q, row_offset_q;
	logic [POS_BITS-1:0] tile_col_q, tile_row_q;

	logic [DIM_BITS-1:0] fw, fh, tw, th;
	logic [DIM_BITS:0]   c, r;
	logic                hit, rd_in;
	logic [DIM_BITS-1:0] nc, nr, co1, ro1;
	logic                col_wrap, tile_end, ovf_col, done;
	logic [POS_BITS-1:0] tile_col_d, tile_row_d;
	logic [DIM_BITS-1:0] col_offset_d, row_offset_d;

	always_comb begin
		fw = frame_width_q;
		if (frame_width_q == '0)                   fw = 9'd1;
		else if (32'(frame_width_q) > MAX_WIDTH)   fw = DIM_BITS'(MAX_WIDTH);
		fh = frame_height_q;
		if (frame_height_q == '0)                  fh = 9'd1;
		else if (32'(frame_height_q) > MAX_HEIGHT) fh = DIM_BITS'(MAX_HEIGHT);
		tw = tile_width;
		if (tile_width == '0)                      tw = 9'd1;
		else if (tile_width > TILE_DIM_MAX)        tw = TILE_DIM_MAX;
		th = tile_height;
		if (tile_height == '0)                     th = 9'd1;
		else if (tile_height > TILE_DIM_MAX)       th = TILE_DIM_MAX;
	end

	assign c     = {1'b0, col_offset_q} + {2'b0, tile_col_q};
	assign r     = {1'b0, row_offset_q} + {2'b0, tile_row_q};
	assign hit   = (c < {1'b0, fw}) && (r < {1'b0, fh});
	assign rd_in = (32'(read_col) < MAX_WIDTH) && (32'(read_row) < MAX_HEIGHT);

	always_comb begin
		if (mode == MODE_READ)
			addr = {RW'(read_row), CW'(read_col)};
		else
			addr = {RW'(r), CW'(c)};
	end

	// position advance
	always_comb begin
		nc         = {1'b0, tile_col_q} + 9'd1;
		nr         = {1'b0, tile_row_q} + 9'd1;
		col_wrap   = nc >= tw;
		tile_end   = col_wrap && (nr >= th);
		tile_col_d = col_wrap ? '0 : nc[POS_BITS-1:0];
		tile_row_d = tile_row_q;
		if (col_wrap)
			tile_row_d = tile_end ? '0 : nr[POS_BITS-1:0];
		co1     = col_offset_q + tw;
		ovf_col = co1 >= fw;
		ro1     = ovf_col ? (row_offset_q + th) : row_offset_q;
		done    = tile_end && (ro1 >= fh);
		col_offset_d = col_offset_q;
		row_offset_d = row_offset_q;
		if (tile_end) begin
			col_offset_d = (ovf_col || done) ? '0 : co1;
			row_offset_d = done ? '0 : ro1;
		end
	end

	always_comb begin
		ctl.mode = mode;
		if (mode == MODE_READ) begin
			ctl.wr_en = rd_in;
			ctl.clip  = 1'b0;
			ctl.done  = 1'b0;
		end else begin
			ctl.wr_en = hit;
			ctl.clip  = !hit;
			ctl.done  = done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_DIM_RESET;
			frame_height_q <= FRAME_DIM_RESET;
			col_offset_q   <= '0;
			row_offset_q   <= '0;
			tile_col_q     <= '0;
			tile_row_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && mode == MODE_PIXEL) begin
				tile_col_q   <= tile_col_d;
				tile_row_q   <= tile_row_d;
				col_offset_q <= col_offset_d;
				row_offset_q <= row_offset_d;
			end
		end
	end

endmodule

// File: src/image_tile_mosaic_builder_top.sv
// Tile mosaic builder: accumulates tile pixels into a frame store, reads/clears pixels.
// Items pass through stage 1 and the output register before m_tvalid rises; m_tready
// stalls hold both. Throughput 1 item per cycle while m_tready does not stall, set by the
// read-modify-write on the store with a write bypass.
// Reset: asynchronous, active low; afterwards the store is zeroed by a sweep over all
// 2**(RW+CW) entries (65536 at default sizes) during which s_tready stays low.
// Configuration writes are taken at any time, cfg_ready is always high.
module image_tile_mosaic_builder_top import itmb_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]     cfg_data,
	// input items
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [15:0] pixel_value, [24:16] tile_width, [33:25] tile_height,
	// [41:34] read_col, [49:42] read_row, [55:50] zero
	input  logic [55:0]             s_tdata,
	// [0] mode
	input  logic [0:0]              s_tuser,
	// result items
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [15:0] read_value
	output logic [15:0]             m_tdata,
	output logic                    m_tlast,   // frame_done
	// [0] clipped
	output logic [0:0]              m_tuser
);

	// store address is {row, col}; each axis padded to a power of two
	localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW = RW + CW;
	localparam int SW = ((PIXEL_BITS > VALUE_BITS) ? PIXEL_BITS : VALUE_BITS) + 1;
	localparam logic signed [SW-1:0] PIX_MAX = SW'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] PIX_MIN = -PIX_MAX - SW'(1);

	// input fields
	logic                         mode;
	logic signed [VALUE_BITS-1:0] pixel_value;
	logic [DIM_BITS-1:0]          tile_width, tile_height;
	logic [POS_BITS-1:0]          read_col, read_row;

	assign mode        = s_tuser[0];
	assign pixel_value = s_tdata[15:0];
	assign tile_width  = s_tdata[24:16];
	assign tile_height = s_tdata[33:25];
	assign read_col    = s_tdata[41:34];
	assign read_row    = s_tdata[49:42];

	logic            clear_busy;
	logic            accept;
	logic            s1_adv;
	logic [AW-1:0]   addr;
	itmb_ctl_t       ctl;

	// stage 1: store read data arrives, sum is formed and written back
	logic                         valid_s1;
	logic [AW-1:0]                addr_s1;
	itmb_ctl_t                    ctl_s1;
	logic signed [VALUE_BITS-1:0] pix_s1;

	// output register
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  done_q, clip_q;

	logic [PIXEL_BITS-1:0]   rd_data;
	logic signed [SW-1:0]    stored, sum, sat;
	logic [PIXEL_BITS-1:0]   wr_data;
	logic [VALUE_BITS-1:0]   read_value;

	assign cfg_ready = 1'b1;

	// stage 1 moves on whenever the output register is free or being drained
	assign s1_adv   = !out_valid_q || m_tready;
	assign s_tready = !clear_busy && (!valid_s1 || s1_adv);
	assign accept   = s_tvalid && s_tready;

	itmb_place #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.RW         (RW)
	) u_place (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.mode        (mode),
		.tile_width  (tile_width),
		.tile_height (tile_height),
		.read_col    (read_col),
		.read_row    (read_row),
		.addr        (addr),
		.ctl         (ctl)
	);

	itmb_store #(
		.AW (AW),
		.DW (PIXEL_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_busy (clear_busy),
		.rd_en      (accept),
		.rd_addr    (addr),
		.rd_data    (rd_data),
		.wr_en      (valid_s1 && s1_adv && ctl_s1.wr_en),
		.wr_addr    (addr_s1),
		.wr_data    (wr_data)
	);

	// saturating accumulate; a read clears the entry
	always_comb begin
		stored = SW'($signed(rd_data));
		sum    = stored + SW'(pix_s1);
		if (sum > PIX_MAX)      sat = PIX_MAX;
		else if (sum < PIX_MIN) sat = PIX_MIN;
		else                    sat = sum;
		if (ctl_s1.mode == MODE_READ) begin
			wr_data    = '0;
			read_value = ctl_s1.wr_en ? stored[VALUE_BITS-1:0] : '0;
		end else begin
			wr_data    = sat[PIXEL_BITS-1:0];
			read_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (valid_s1 && s1_adv)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr;
			ctl_s1  <= ctl;
			pix_s1  <= pixel_value;
		end
		if (valid_s1 && s1_adv) begin
			read_value_q <= read_value;
			done_q       <= ctl_s1.done;
			clip_q       <= ctl_s1.clip;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = read_value_q;
	assign m_tlast    = done_q;
	assign m_tuser[0] = clip_q;

endmodule

// File: dv/mosaic_result_check.sv
`timescale 1ns / 100ps
// Result checker for the tile mosaic builder: tracks config writes and input items,
// predicts each result and compares it with the output channel. Depends on itmb_pkg.
module mosaic_result_check import itmb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]     cfg_data,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [55:0]             s_tdata,
	input  logic [0:0]              s_tuser,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [15:0]             m_tdata,
	input  logic                    m_tlast,
	input  logic [0:0]              m_tuser,
	output int                      errors,
	output int                      pending
);

	localparam int STORE_COLS  = 256;
	localparam int STORE_DEPTH = 65536;
	localparam int DIM_LIMIT   = 256;
	localparam int PIX_MAX     = 2 ** (VALUE_BITS - 1) - 1;
	localparam int PIX_MIN     = -(2 ** (VALUE_BITS - 1));

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] read_value;
		logic                         frame_done;
		logic                         clipped;
	} mosaic_result_t;

	logic signed [VALUE_BITS-1:0] frame_copy [STORE_DEPTH];
	logic [DIM_BITS-1:0] frame_w_reg, frame_h_reg;
	logic [DIM_BITS-1:0] col_base, row_base;
	logic [POS_BITS-1:0] col_in_tile, row_in_tile;
	mosaic_result_t      expected_results [$];
	mosaic_result_t      predicted, oldest;

	// 0 acts as 1, anything above the store size acts as the store size
	function automatic int eff_dim(input logic [DIM_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return int'(v);
	endfunction

	task automatic mosaic_update(input logic [55:0] data, input logic mode,
			output mosaic_result_t res);
		int fw, fh, tw, th, col, row, idx, sum, next_col, next_row;
		logic signed [VALUE_BITS-1:0] pix;
		logic tile_end;
		res = '0;
		if (mode == MODE_READ) begin
			idx = int'(data[49:42]) * STORE_COLS + int'(data[41:34]);
			res.read_value = frame_copy[idx];
			frame_copy[idx] = '0;
		end else begin
			fw  = eff_dim(frame_w_reg);
			fh  = eff_dim(frame_h_reg);
			tw  = eff_dim(data[24:16]);
			th  = eff_dim(data[33:25]);
			pix = data[15:0];
			col = int'(col_base) + int'(col_in_tile);
			row = int'(row_base) + int'(row_in_tile);
			if (col < fw && row < fh) begin
				idx = row * STORE_COLS + col;
				sum = int'(frame_copy[idx]) + int'(pix);
				if (sum > PIX_MAX)
					sum = PIX_MAX;
				else if (sum < PIX_MIN)
					sum = PIX_MIN;
				frame_copy[idx] = sum[VALUE_BITS-1:0];
			end else begin
				res.clipped = 1'b1;
			end
			// position wraps against the size presented with this pixel
			next_col = int'(col_in_tile) + 1;
			next_row = int'(row_in_tile);
			tile_end = 1'b0;
			if (next_col >= tw) begin
				next_col = 0;
				next_row++;
				if (next_row >= th) begin
					next_row = 0;
					tile_end = 1'b1;
				end
			end
			col_in_tile = next_col[POS_BITS-1:0];
			row_in_tile = next_row[POS_BITS-1:0];
			if (tile_end) begin
				col_base = col_base + tw[DIM_BITS-1:0];
				if (col_base >= fw) begin
					row_base = row_base + th[DIM_BITS-1:0];
					col_base = '0;
				end
				if (row_base >= fh) begin
					row_base = '0;
					col_base = '0;
					res.frame_done = 1'b1;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				frame_copy[i] = '0;
			frame_w_reg = FRAME_DIM_RESET;
			frame_h_reg = FRAME_DIM_RESET;
			col_base    = '0;
			row_base    = '0;
			col_in_tile = '0;
			row_in_tile = '0;
			expected_results.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAME_WIDTH)
					frame_w_reg = cfg_data;
				else
					frame_h_reg = cfg_data;
			end
			// results trail inputs, so compare before pushing
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no expected result pending");
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					if (m_tdata !== oldest.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							oldest.read_value, $signed(m_tdata));
						errors++;
					end
					if (m_tlast !== oldest.frame_done) begin
						$error("frame_done: expected %0d, actual %0d",
							oldest.frame_done, m_tlast);
						errors++;
					end
					if (m_tuser[0] !== oldest.clipped) begin
						$error("clipped: expected %0d, actual %0d",
							oldest.clipped, m_tuser[0]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				mosaic_update(s_tdata, s_tuser[0], predicted);
				expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the tile mosaic builder testbench: clock, reset, config, item stimulus, verdict.
// Depends on itmb_pkg, image_tile_mosaic_builder_top and mosaic_result_check.
module testbench;
	import itmb_pkg::*;

	// reset sweep of the store covers 65536 entries with no item accepted; stalls are short
	localparam int WATCHDOG_LIMIT  = 300000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 242;
	localparam int DRAIN_CYCLES    = 16;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [DIM_BITS-1:0]     cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [55:0]             s_tdata;
	logic [0:0]              s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [15:0]             m_tdata;
	logic                    m_tlast;
	logic [0:0]              m_tuser;
	int                      errors;
	int                      pending;

	logic calm;             // when set, neither side idles
	int   idle_cycles = 0;  // cycles since the last accepted item on any channel
	int   sink_stall;

	// frame sizes per random phase; 0 and 511 exercise the clamping
	logic [DIM_BITS-1:0] plan_w [PHASES] = '{9'd0, 9'd511, 9'd8, 9'd5, 9'd256, 9'd1, 9'd257, 9'd0};
	logic [DIM_BITS-1:0] plan_h [PHASES] = '{9'd0, 9'd511, 9'd8, 9'd3, 9'd1, 9'd256, 9'd6, 9'd0};

	image_tile_mosaic_builder_top i_dut (.*);

	mosaic_result_check i_mosaic_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Pixel values lean on the extremes so the store saturates now and then
	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h7000;
			3: return 16'h9000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Tile dims: mostly small, sometimes medium, rarely the zero code
	function automatic logic [DIM_BITS-1:0] pick_tile_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return DIM_BITS'($urandom_range(1, 4));
		if (r < 95)
			return DIM_BITS'($urandom_range(5, 12));
		return '0;
	endfunction

	// Result sink: random stall / ready bursts
	initial begin
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			sink_stall = idle_len();
			if (sink_stall > 0) begin
				m_tready <= 1'b0;
				repeat (sink_stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Watchdog: ends the run if no channel moves an item for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Width then height, valid held high across both items
	task automatic set_frame_size(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One input item; returns right after the accepting edge with tvalid still high,
	// so items sent with no gap between them keep tvalid high
	task automatic send_item(input logic mode, input logic [15:0] pixel,
			input logic [DIM_BITS-1:0] tw, input logic [DIM_BITS-1:0] th,
			input logic [POS_BITS-1:0] rc, input logic [POS_BITS-1:0] rr);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'b0, rr, rc, th, tw, pixel};
		do @(posedge clk); while (!s_tready);
	endtask

	// Tile pixel; read fields carry junk that must be ignored
	task automatic send_pixel(input logic [15:0] pixel, input logic [DIM_BITS-1:0] tw,
			input logic [DIM_BITS-1:0] th);
		send_item(MODE_PIXEL, pixel, tw, th, POS_BITS'($urandom), POS_BITS'($urandom));
	endtask

	// Read-and-clear; pixel and tile fields carry junk
	task automatic send_read(input logic [POS_BITS-1:0] rc, input logic [POS_BITS-1:0] rr);
		send_item(MODE_READ, 16'($urandom), DIM_BITS'($urandom), DIM_BITS'($urandom),
			rc, rr);
	endtask

	// Stop sending and wait until every expected result has come back.
	// Checked on the falling edge so the checker's update at the rising edge is settled.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Random phase: mostly whole tiles of random content with reads mixed in,
	// the rest noise items of any shape and tiles cut short
	task automatic random_phase(input int count);
		int sent, len, r;
		logic [DIM_BITS-1:0] tw, th;
		logic [POS_BITS-1:0] rc, rr;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_item(1'($urandom_range(0, 1)), 16'($urandom),
					DIM_BITS'($urandom_range(0, 511)), DIM_BITS'($urandom_range(0, 511)),
					POS_BITS'($urandom), POS_BITS'($urandom));
				sent++;
			end else begin
				tw  = pick_tile_dim();
				th  = pick_tile_dim();
				len = ((tw == '0) ? 1 : int'(tw)) * ((th == '0) ? 1 : int'(th));
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(1, len);
				for (int p = 0; p < len && sent < count; p++) begin
					if ($urandom_range(0, 5) == 0) begin
						// reads mostly land where small frames get written
						if ($urandom_range(0, 3) == 0) begin
							rc = POS_BITS'($urandom);
							rr = POS_BITS'($urandom);
						end else begin
							rc = POS_BITS'($urandom_range(0, 15));
							rr = POS_BITS'($urandom_range(0, 15));
						end
						send_read(rc, rr);
						sent++;
					end
					send_pixel(pick_pixel(), tw, th);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_PIXEL;
		calm      = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on a 2x1 frame: every second pixel of a 2x1 tile closes the frame
		set_frame_size(9'd2, 9'd1);
		send_pixel(16'h7FFF, 9'd2, 9'd1);
		send_pixel(16'h8000, 9'd2, 9'd1);      // frame done
		send_pixel(16'h7FFF, 9'd2, 9'd1);      // positive saturation
		send_pixel(16'h8000, 9'd2, 9'd1);      // negative saturation, frame done
		send_pixel(16'h0001, 9'd0, 9'd0);      // zero tile size acts as 1x1
		send_pixel(16'h0000, 9'd511, 9'd511);  // oversized tile acts as 256x256
		send_pixel(16'hFFFB, 9'd1, 9'd1);      // size shrinks mid-tile: clipped, wraps, done
		send_read(8'd0, 8'd0);
		send_read(8'd0, 8'd0);                 // already cleared
		send_read(8'd1, 8'd0);
		send_read(8'd255, 8'd255);             // far corner, outside the frame
		send_pixel(16'h0100, 9'd256, 9'd1);
		send_pixel(16'h7FFF, 9'h1FF, 9'h1FF);
		send_pixel(16'h5555, 9'd1, 9'd1);      // off the right edge: clipped
		send_read(8'd0, 8'd0);
		send_read(8'd1, 8'd0);
		drain_results();

		// Random phases, each under its own frame size; registers only change when idle
		for (int phase = 0; phase < PHASES; phase++) begin
			calm = (phase == 2) || ($urandom_range(0, 4) == 0);
			if (phase == PHASES - 1)
				set_frame_size(DIM_BITS'($urandom_range(1, 16)),
					DIM_BITS'($urandom_range(1, 16)));
			else
				set_frame_size(plan_w[phase], plan_h[phase]);
			random_phase(ITEMS_PER_PHASE);
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
src/itmb_pkg.sv
src/itmb_store.sv
src/itmb_place.sv
src/image_tile_mosaic_builder_top.sv
dv/mosaic_result_check.sv
dv/testbench.sv
